/* sv/ejsj_pkg.sv */
package ejsj_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // accepted byte together with the lead state seen when it arrived
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
      logic       pending;
      logic [7:0] lead;
   } stage_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } result_type;

   localparam logic [7:0]  KanaLead    = 8'h8e;
   localparam logic [7:0]  KanaLow     = 8'ha0;
   localparam logic [7:0]  KanaHigh    = 8'hdf;
   localparam logic [5:0]  KanaBase    = 6'h20;
   localparam logic [15:0] JisMask     = 16'h7f7f;
   localparam logic [7:0]  OddAdd      = 8'h1f;
   localparam logic [7:0]  EvenAdd     = 8'h7d;
   localparam logic [7:0]  LoGap       = 8'h7f;
   localparam logic [15:0] RowBase     = 16'h0021;
   localparam logic [15:0] SjisBase    = 16'h0081;
   localparam logic [15:0] SjisGapTop  = 16'h009f;
   localparam logic [15:0] SjisGapSkip = 16'h0040;
   localparam int unsigned QueueDepth  = 4;

   localparam logic [15:0] KANA_TO_JIS [64] = '{
      16'h2121, 16'h2123, 16'h2156, 16'h2157, 16'h2122, 16'h2126, 16'h2572, 16'h2521,
      16'h2523, 16'h2525, 16'h2527, 16'h2529, 16'h2563, 16'h2565, 16'h2567, 16'h2543,
      16'h213c, 16'h2522, 16'h2524, 16'h2526, 16'h2528, 16'h252a, 16'h252b, 16'h252d,
      16'h252f, 16'h2531, 16'h2533, 16'h2535, 16'h2537, 16'h2539, 16'h253b, 16'h253d,
      16'h253f, 16'h2541, 16'h2544, 16'h2546, 16'h2548, 16'h254a, 16'h254b, 16'h254c,
      16'h254d, 16'h254e, 16'h254f, 16'h2552, 16'h2555, 16'h2558, 16'h255b, 16'h255e,
      16'h255f, 16'h2560, 16'h2561, 16'h2562, 16'h2564, 16'h2566, 16'h2568, 16'h2569,
      16'h256a, 16'h256b, 16'h256c, 16'h256d, 16'h256f, 16'h2573, 16'h212b, 16'h212c
   };

   function automatic logic [15:0] pair_to_sjis(input logic [7:0] lead,
                                                input logic [7:0] trail);
      logic [15:0] jis;
      logic [15:0] hi;
      logic [7:0]  lo;
      logic [5:0]  idx;
      idx = trail[5:0] - KanaBase;
      if (lead == KanaLead) begin
         jis = (trail >= KanaLow && trail <= KanaHigh) ? KANA_TO_JIS[idx] : 16'h0000;
      end else begin
         jis = {lead, trail} & JisMask;
      end
      hi = {8'h00, jis[15:8]};
      lo = jis[7:0];
      lo = lo + (hi[0] ? OddAdd : EvenAdd);
      if (lo >= LoGap) begin
         lo = lo + 8'h01;
      end
      hi = ((hi - RowBase) >> 1) + SjisBase;
      if (hi > SjisGapTop) begin
         hi = hi + SjisGapSkip;
      end
      return {hi[7:0], lo};
   endfunction

endpackage

/* sv/ejsj_conv.sv */
module ejsj_conv (
   input  ejsj_pkg::stage_type  stage,
   output ejsj_pkg::result_type result
);

   logic [7:0]  lead;
   logic [7:0]  trail;
   logic [15:0] sj;

   assign lead  = stage.pending ? stage.lead : stage.in_byte;
   assign trail = stage.pending ? stage.in_byte : 8'h00;
   assign sj    = ejsj_pkg::pair_to_sjis(lead, trail);

   always_comb begin
      result.count           = 2'd0;
      result.first.out_byte  = sj[15:8];
      result.first.out_last  = 1'b0;
      result.second.out_byte = sj[7:0];
      result.second.out_last = stage.in_last;
      priority if (stage.pending) begin
         result.count = 2'd2;
      end else if (!stage.in_byte[7]) begin
         // plain ascii byte passes through
         result.count          = 2'd1;
         result.first.out_byte = stage.in_byte;
         result.first.out_last = stage.in_last;
      end else if (stage.in_last) begin
         // lone lead at end of text pairs with a zero trail
         result.count = 2'd2;
      end else begin
         result.count = 2'd0;
      end
   end

endmodule

/* sv/euc_jp_to_shift_jis_stream_top.sv */
// EUC-JP to Shift-JIS byte stream converter. One input byte is taken per clock
// when the result side keeps up; a byte enters an input register, is converted
// by a short table lookup and adds, and its zero, one or two Shift-JIS bytes are
// written to a four-entry result queue. The result port moves one byte per cycle
// while rsp_stall is low, so a two-byte pair keeps the sustained rate at one
// byte per cycle, while a lone lead byte marked last gives two result bytes
// for one input transaction. The input stalls when the queue lacks room for
// the staged byte's results.
module euc_jp_to_shift_jis_stream_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ejsj_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ejsj_pkg::rsp_type rsp_data
);

   logic                   lead_pending_ff, lead_pending_in;
   logic [7:0]             held_lead_ff, held_lead_in;
   logic                   s_valid_ff, s_valid_in;
   ejsj_pkg::stage_type    stage_ff, stage_in;
   ejsj_pkg::result_type   result;
   ejsj_pkg::rsp_type      q_ff [ejsj_pkg::QueueDepth];
   logic [1:0]             head_ff, head_in;
   logic [1:0]             tail_ff, tail_in;
   logic [2:0]             count_ff, count_in;
   logic [3:0]             room_need;
   logic                   accept;
   logic                   s_move;
   logic                   pop;
   logic                   push_one;
   logic                   push_two;

   ejsj_conv u_conv (
      .stage  (stage_ff),
      .result (result)
   );

   assign room_need = {1'b0, count_ff} + {2'b00, result.count};
   assign s_move    = s_valid_ff && (room_need <= 4'(ejsj_pkg::QueueDepth));
   assign req_stall = s_valid_ff && !s_move;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = q_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign push_one  = s_move && (result.count != 2'd0);
   assign push_two  = s_move && (result.count == 2'd2);

   always_comb begin
      lead_pending_in = lead_pending_ff;
      held_lead_in    = held_lead_ff;
      stage_in        = stage_ff;
      s_valid_in      = s_valid_ff;
      if (s_move) begin
         s_valid_in = 1'b0;
      end
      if (accept) begin
         s_valid_in       = 1'b1;
         stage_in.in_byte = req_data.in_byte;
         stage_in.in_last = req_data.in_last;
         stage_in.pending = lead_pending_ff;
         stage_in.lead    = held_lead_ff;
         priority if (lead_pending_ff) begin
            lead_pending_in = 1'b0;
         end else if (req_data.in_byte[7] && !req_data.in_last) begin
            lead_pending_in = 1'b1;
            held_lead_in    = req_data.in_byte;
         end else begin
            lead_pending_in = lead_pending_ff;
         end
      end
      head_in  = head_ff + {1'b0, pop};
      tail_in  = tail_ff + {push_two, push_one && !push_two};
      count_in = count_ff + {1'b0, push_two, push_one && !push_two} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         held_lead_ff    <= 8'h00;
         s_valid_ff      <= 1'b0;
         head_ff         <= 2'd0;
         tail_ff         <= 2'd0;
         count_ff        <= 3'd0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         held_lead_ff    <= held_lead_in;
         s_valid_ff      <= s_valid_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   always_ff @(posedge clock) begin
      if (push_one) begin
         q_ff[tail_ff] <= result.first;
      end
      if (push_two) begin
         q_ff[tail_ff + 2'd1] <= result.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(ejsj_pkg::QueueDepth))
      else $error("result queue count out of range");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == 3'd0 |-> head_ff == tail_ff)
      else $error("empty queue with unequal pointers");

   a_held_lead: assert property (@(posedge clock) disable iff (reset)
      lead_pending_ff |-> held_lead_ff[7])
      else $error("held lead below 0x80");

   a_pair_close: assert property (@(posedge clock) disable iff (reset)
      accept && lead_pending_ff |=> !lead_pending_ff && s_valid_ff && stage_ff.pending)
      else $error("trail transaction did not close the held pair");

endmodule
